@@ hw/rtl/rational_accumulator_alu_defines.svh @@
// assertion macros for the rational accumulator alu checker
`ifndef RATIONAL_ACCUMULATOR_ALU_DEFINES_SVH
`define RATIONAL_ACCUMULATOR_ALU_DEFINES_SVH

// clocked assertion, disabled while reset is low
`define RAA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies another in the next
`define RAA_ASSERT_NEXT(lbl, pre, post, msg) \
    `RAA_ASSERT(lbl, pre |=> post, msg)

`endif

@@ hw/rtl/rac_pkg.sv @@
// shared types and codes for the rational accumulator alu
`default_nettype none
package rac_pkg;

    localparam logic [2:0] CMD_LOAD = 3'd0;
    localparam logic [2:0] CMD_ADD  = 3'd1;
    localparam logic [2:0] CMD_SUB  = 3'd2;
    localparam logic [2:0] CMD_MUL  = 3'd3;
    localparam logic [2:0] CMD_DIV  = 3'd4;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZERO = 2'd1;
    localparam logic [1:0] STAT_OVF  = 2'd2;

    typedef enum logic [1:0] {
        UOP_MUL,
        UOP_DIV,
        UOP_GCD
    } uop_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OG,
        S_OQ1,
        S_OQ2,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_COMB,
        S_CZ,
        S_CG,
        S_CQ1,
        S_CQ2,
        S_CHK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic start;
        uop_t op;
    } unit_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } unit_rsp_t;

endpackage
`default_nettype wire

@@ hw/rtl/rac_unit.sv @@
// shared 64-bit unit: shift-add multiply, restoring divide, binary gcd
`default_nettype none
module rac_unit
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rac_pkg::unit_req_t req,
    input  wire logic [63:0]       a,
    input  wire logic [63:0]       b,
    output rac_pkg::unit_rsp_t     rsp
);

    logic [63:0]   a_reg, a_next;
    logic [63:0]   b_reg, b_next;
    logic [64:0]   r_reg, r_next;
    logic [5:0]    k_reg, k_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [63:0]   res_reg, res_next;
    rac_pkg::uop_t op_reg, op_next;
    logic [64:0]   rem_sh;
    logic          q_bit;

    assign rem_sh = {r_reg[63:0], a_reg[63]};
    assign q_bit  = (rem_sh >= {1'b0, b_reg});

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        k_next    = k_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        op_next   = op_reg;
        if (req.start)
        begin
            a_next    = a;
            b_next    = b;
            r_next    = '0;
            k_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            op_next   = req.op;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                rac_pkg::UOP_MUL:
                begin
                    if (b_reg == 64'd0)
                    begin
                        res_next  = r_reg[63:0];
                        done_next = 1'b1;
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        if (b_reg[0])
                        begin
                            r_next = r_reg + {1'b0, a_reg};
                        end
                        a_next = {a_reg[62:0], 1'b0};
                        b_next = {1'b0, b_reg[63:1]};
                    end
                end
                rac_pkg::UOP_DIV:
                begin
                    // one quotient bit per cycle
                    r_next   = q_bit ? (rem_sh - {1'b0, b_reg}) : rem_sh;
                    a_next   = {a_reg[62:0], q_bit};
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        res_next  = {a_reg[62:0], q_bit};
                        done_next = 1'b1;
                        busy_next = 1'b0;
                    end
                end
                rac_pkg::UOP_GCD:
                begin
                    if (a_reg == b_reg)
                    begin
                        res_next  = a_reg << k_reg;
                        done_next = 1'b1;
                        busy_next = 1'b0;
                    end
                    else if (!a_reg[0] && !b_reg[0])
                    begin
                        a_next = {1'b0, a_reg[63:1]};
                        b_next = {1'b0, b_reg[63:1]};
                        k_next = k_reg + 6'd1;
                    end
                    else if (!a_reg[0])
                    begin
                        a_next = {1'b0, a_reg[63:1]};
                    end
                    else if (!b_reg[0])
                    begin
                        b_next = {1'b0, b_reg[63:1]};
                    end
                    else if (a_reg > b_reg)
                    begin
                        a_next = a_reg - b_reg;
                    end
                    else
                    begin
                        b_next = b_reg - a_reg;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= rac_pkg::UOP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        r_reg   <= r_next;
        k_reg   <= k_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule
`default_nettype wire

@@ hw/rtl/rational_accumulator_alu.sv @@
// top level of the rational accumulator alu
`default_nettype none
// Rational accumulator: holds one fraction in lowest terms with a positive
// denominator and applies load, add, subtract, multiply or divide with an
// operand fraction per request. One request is taken at a time; s_tready is
// low from acceptance until its result has been taken on the master side.
// Multiplies, divisions and gcds run through one shared 64-bit unit
// (shift-add multiply, 64-step restoring divide, binary gcd) under a
// sequencer. An unused command or a zero denominator shows its result in
// the cycle right after acceptance; a full add or subtract uses two gcds,
// four divisions and three multiplies. Errors (zero denominator, zero
// divisor, result out of WIDTH range) leave the accumulator unchanged and
// the result shows the unchanged accumulator with the error status. Unused
// commands leave the accumulator unchanged with status ok.
module rational_accumulator_alu
#(
    parameter int WIDTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // operand_num[31:0], operand_den[63:32]
    input  wire logic [2:0]  s_tuser,   // cmd[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // result_num[31:0], result_den[62:32], zero[63]
    output logic [1:0]       m_tuser    // status[1:0]
);

    localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);

    rac_pkg::state_t state_reg, state_next;

    logic [2:0]  cmd_reg, cmd_next;
    logic [63:0] on_reg, on_next;
    logic [63:0] od_reg, od_next;
    logic [63:0] g_reg, g_next;
    logic [63:0] t1_reg, t1_next;
    logic [63:0] t2_reg, t2_next;
    logic [63:0] mag_reg, mag_next;
    logic [63:0] den_reg, den_next;
    logic        oneg_reg, oneg_next;
    logic        rneg_reg, rneg_next;
    logic [31:0] acc_num_reg, acc_num_next;
    logic [30:0] acc_den_reg, acc_den_next;
    logic [1:0]  status_reg, status_next;
    logic        issued_reg;

    // operand and accumulator magnitudes
    logic        nneg, dneg, aneg, s2;
    logic [31:0] nmag, dmag;
    logic [63:0] amag, aden;

    rac_pkg::unit_req_t u_req;
    rac_pkg::unit_rsp_t u_rsp;
    logic               u_use;
    logic [63:0]        u_a, u_b;

    assign nneg = s_tdata[31];
    assign dneg = s_tdata[63];
    assign nmag = nneg ? (~s_tdata[31:0] + 32'd1) : s_tdata[31:0];
    assign dmag = dneg ? (~s_tdata[63:32] + 32'd1) : s_tdata[63:32];
    assign aneg = acc_num_reg[31];
    assign amag = {32'd0, aneg ? (~acc_num_reg + 32'd1) : acc_num_reg};
    assign aden = {33'd0, acc_den_reg};
    // sign of the operand term for add and subtract
    assign s2   = (cmd_reg == rac_pkg::CMD_SUB) ? !oneg_reg : oneg_reg;

    // next state and datapath
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        on_next      = on_reg;
        od_next      = od_reg;
        g_next       = g_reg;
        t1_next      = t1_reg;
        t2_next      = t2_reg;
        mag_next     = mag_reg;
        den_next     = den_reg;
        oneg_next    = oneg_reg;
        rneg_next    = rneg_reg;
        acc_num_next = acc_num_reg;
        acc_den_next = acc_den_reg;
        status_next  = status_reg;
        case (state_reg)
            rac_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next  = s_tuser;
                    on_next   = {32'd0, nmag};
                    od_next   = {32'd0, dmag};
                    oneg_next = nneg ^ dneg;
                    if (s_tuser > rac_pkg::CMD_DIV)
                    begin
                        status_next = rac_pkg::STAT_OK;
                        state_next  = rac_pkg::S_OUT;
                    end
                    else if (dmag == 32'd0)
                    begin
                        status_next = rac_pkg::STAT_ZERO;
                        state_next  = rac_pkg::S_OUT;
                    end
                    else if (nmag == 32'd0)
                    begin
                        on_next    = 64'd0;
                        od_next    = 64'd1;
                        oneg_next  = 1'b0;
                        state_next = rac_pkg::S_MUL1;
                    end
                    else
                    begin
                        state_next = rac_pkg::S_OG;
                    end
                end
            end
            rac_pkg::S_OG:
            begin
                if (u_rsp.done)
                begin
                    g_next     = u_rsp.res;
                    state_next = rac_pkg::S_OQ1;
                end
            end
            rac_pkg::S_OQ1:
            begin
                if (u_rsp.done)
                begin
                    on_next    = u_rsp.res;
                    state_next = rac_pkg::S_OQ2;
                end
            end
            rac_pkg::S_OQ2:
            begin
                if (u_rsp.done)
                begin
                    od_next    = u_rsp.res;
                    state_next = rac_pkg::S_MUL1;
                end
            end
            rac_pkg::S_MUL1:
            begin
                if (cmd_reg == rac_pkg::CMD_LOAD)
                begin
                    mag_next   = on_reg;
                    den_next   = od_reg;
                    rneg_next  = oneg_reg;
                    state_next = rac_pkg::S_CZ;
                end
                else if (cmd_reg == rac_pkg::CMD_DIV && on_reg == 64'd0)
                begin
                    status_next = rac_pkg::STAT_ZERO;
                    state_next  = rac_pkg::S_OUT;
                end
                else if (u_rsp.done)
                begin
                    if (cmd_reg == rac_pkg::CMD_ADD || cmd_reg == rac_pkg::CMD_SUB)
                    begin
                        t1_next = u_rsp.res;
                    end
                    else
                    begin
                        mag_next = u_rsp.res;
                    end
                    state_next = rac_pkg::S_MUL2;
                end
            end
            rac_pkg::S_MUL2:
            begin
                if (u_rsp.done)
                begin
                    if (cmd_reg == rac_pkg::CMD_ADD || cmd_reg == rac_pkg::CMD_SUB)
                    begin
                        t2_next    = u_rsp.res;
                        state_next = rac_pkg::S_MUL3;
                    end
                    else
                    begin
                        den_next   = u_rsp.res;
                        rneg_next  = aneg ^ oneg_reg;
                        state_next = rac_pkg::S_CZ;
                    end
                end
            end
            rac_pkg::S_MUL3:
            begin
                if (u_rsp.done)
                begin
                    den_next   = u_rsp.res;
                    state_next = rac_pkg::S_COMB;
                end
            end
            rac_pkg::S_COMB:
            begin
                // signed sum of the two cross products
                if (aneg == s2)
                begin
                    mag_next  = t1_reg + t2_reg;
                    rneg_next = aneg;
                end
                else if (t1_reg >= t2_reg)
                begin
                    mag_next  = t1_reg - t2_reg;
                    rneg_next = aneg;
                end
                else
                begin
                    mag_next  = t2_reg - t1_reg;
                    rneg_next = s2;
                end
                state_next = rac_pkg::S_CZ;
            end
            rac_pkg::S_CZ:
            begin
                if (mag_reg == 64'd0)
                begin
                    acc_num_next = 32'd0;
                    acc_den_next = 31'd1;
                    status_next  = rac_pkg::STAT_OK;
                    state_next   = rac_pkg::S_OUT;
                end
                else
                begin
                    state_next = rac_pkg::S_CG;
                end
            end
            rac_pkg::S_CG:
            begin
                if (u_rsp.done)
                begin
                    g_next     = u_rsp.res;
                    state_next = rac_pkg::S_CQ1;
                end
            end
            rac_pkg::S_CQ1:
            begin
                if (u_rsp.done)
                begin
                    mag_next   = u_rsp.res;
                    state_next = rac_pkg::S_CQ2;
                end
            end
            rac_pkg::S_CQ2:
            begin
                if (u_rsp.done)
                begin
                    den_next   = u_rsp.res;
                    state_next = rac_pkg::S_CHK;
                end
            end
            rac_pkg::S_CHK:
            begin
                // range check against WIDTH before writing back
                if (den_reg > LIM - 64'd1 ||
                    (rneg_reg ? (mag_reg > LIM) : (mag_reg > LIM - 64'd1)))
                begin
                    status_next = rac_pkg::STAT_OVF;
                end
                else
                begin
                    acc_num_next = rneg_reg ? (32'd0 - mag_reg[31:0]) : mag_reg[31:0];
                    acc_den_next = den_reg[30:0];
                    status_next  = rac_pkg::STAT_OK;
                end
                state_next = rac_pkg::S_OUT;
            end
            rac_pkg::S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = rac_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rac_pkg::S_IDLE;
            end
        endcase
    end

    // unit requests and handshake outputs
    always_comb
    begin
        u_use   = 1'b0;
        u_a     = on_reg;
        u_b     = od_reg;
        u_req.op = rac_pkg::UOP_MUL;
        case (state_reg)
            rac_pkg::S_OG:
            begin
                u_use    = 1'b1;
                u_req.op = rac_pkg::UOP_GCD;
            end
            rac_pkg::S_OQ1:
            begin
                u_use    = 1'b1;
                u_req.op = rac_pkg::UOP_DIV;
                u_b      = g_reg;
            end
            rac_pkg::S_OQ2:
            begin
                u_use    = 1'b1;
                u_req.op = rac_pkg::UOP_DIV;
                u_a      = od_reg;
                u_b      = g_reg;
            end
            rac_pkg::S_MUL1:
            begin
                u_use = (cmd_reg != rac_pkg::CMD_LOAD) &&
                        !(cmd_reg == rac_pkg::CMD_DIV && on_reg == 64'd0);
                u_a   = amag;
                u_b   = (cmd_reg == rac_pkg::CMD_MUL) ? on_reg : od_reg;
            end
            rac_pkg::S_MUL2:
            begin
                u_use = 1'b1;
                if (cmd_reg == rac_pkg::CMD_ADD || cmd_reg == rac_pkg::CMD_SUB)
                begin
                    u_a = on_reg;
                    u_b = aden;
                end
                else
                begin
                    u_a = aden;
                    u_b = (cmd_reg == rac_pkg::CMD_DIV) ? on_reg : od_reg;
                end
            end
            rac_pkg::S_MUL3:
            begin
                u_use = 1'b1;
                u_a   = aden;
                u_b   = od_reg;
            end
            rac_pkg::S_CG:
            begin
                u_use    = 1'b1;
                u_req.op = rac_pkg::UOP_GCD;
                u_a      = mag_reg;
                u_b      = den_reg;
            end
            rac_pkg::S_CQ1:
            begin
                u_use    = 1'b1;
                u_req.op = rac_pkg::UOP_DIV;
                u_a      = mag_reg;
                u_b      = g_reg;
            end
            rac_pkg::S_CQ2:
            begin
                u_use    = 1'b1;
                u_req.op = rac_pkg::UOP_DIV;
                u_a      = den_reg;
                u_b      = g_reg;
            end
            default:
            begin
                u_use = 1'b0;
            end
        endcase
        u_req.start = u_use && !issued_reg;
        s_tready    = (state_reg == rac_pkg::S_IDLE);
        m_tvalid    = (state_reg == rac_pkg::S_OUT);
    end

    assign m_tdata = {1'b0, acc_den_reg, acc_num_reg};
    assign m_tuser = status_reg;

    rac_unit u_unit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (u_req),
        .a     (u_a),
        .b     (u_b),
        .rsp   (u_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rac_pkg::S_IDLE;
            issued_reg  <= 1'b0;
            acc_num_reg <= 32'd0;
            acc_den_reg <= 31'd1;
            status_reg  <= rac_pkg::STAT_OK;
        end
        else
        begin
            state_reg   <= state_next;
            issued_reg  <= u_rsp.done ? 1'b0 : (u_req.start ? 1'b1 : issued_reg);
            acc_num_reg <= acc_num_next;
            acc_den_reg <= acc_den_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        on_reg   <= on_next;
        od_reg   <= od_next;
        g_reg    <= g_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        mag_reg  <= mag_next;
        den_reg  <= den_next;
        oneg_reg <= oneg_next;
        rneg_reg <= rneg_next;
    end

endmodule
`default_nettype wire

@@ hw/rtl/rac_checker.sv @@
// port-level checker for the rational accumulator alu, with its bind
`default_nettype none
`include "rational_accumulator_alu_defines.svh"
module rac_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    `RAA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `RAA_ASSERT(a_den_pos, m_tvalid |-> m_tdata[62:32] != 31'd0, "zero result denominator")
    `RAA_ASSERT(a_one_at_a_time, s_tready |-> !m_tvalid, "ready while a result is pending")
    `RAA_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "ready right after a request")
    `RAA_ASSERT(a_status_code, m_tvalid |-> m_tuser <= rac_pkg::STAT_OVF, "unknown status code")

endmodule

bind rational_accumulator_alu rac_checker u_rac_checker (.*);
`default_nettype wire
